FILE: hw/rtl/nfa_pkg.sv
// Shared types and constants for the next-fit identifier allocator.
// Used by nfa_ctrl, nfa_datapath and next_fit_id_allocator_core; no dependencies.
`default_nettype none

package nfa_pkg;

	localparam int CAPACITY = 1024;
	localparam int ID_W     = 16;
	localparam int SPAN_W   = 11;
	localparam int ACT_W    = 2;
	localparam int ST_W     = 2;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int WORD_W   = 32;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int ROWS     = CAPACITY / WORD_W;
	localparam int ROW_W    = IDX_W - BIT_W;

	localparam int RESET_LOWEST   = 100;
	localparam int RESET_SPAN     = 901;
	localparam int RESET_SPAN_EFF = (RESET_SPAN > CAPACITY) ? CAPACITY : RESET_SPAN;
	localparam int RESET_LAST     = (RESET_SPAN_EFF == 0) ? 0 : RESET_SPAN_EFF - 1;

	localparam logic [ACT_W-1:0] ACT_ALLOC   = ACT_W'(0);
	localparam logic [ACT_W-1:0] ACT_RELEASE = ACT_W'(1);
	localparam logic [ACT_W-1:0] ACT_CLEAR   = ACT_W'(2);

	localparam logic [ST_W-1:0] ST_DONE         = ST_W'(0);
	localparam logic [ST_W-1:0] ST_NONE_FREE    = ST_W'(1);
	localparam logic [ST_W-1:0] ST_OUT_OF_RANGE = ST_W'(2);

	localparam logic CFG_LOWEST_ID = 1'b0;
	localparam logic CFG_ID_SPAN   = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]   lowest;
		logic [SPAN_W-1:0] span;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic scan_step;
		logic commit;
		logic rel_write;
		logic emit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic span_zero;
		logic found;
		logic exhausted;
	} dp_status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/next_fit_id_allocator_core.sv
// Next-fit identifier allocator: top level with configuration registers,
// result register and checks. Depends on nfa_pkg, nfa_ctrl and nfa_datapath.
//
// Input channel (in_valid/in_stall, action, requested_id): one action per
// transaction. Output channel (out_valid/out_stall, issued_id, status): exactly
// one result per input transaction, in order. Configuration channel
// (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 writes lowest_id,
// index 1 writes id_span; cfg_ready is always high.
// One item is worked on at a time. The bitmap sits in a 32-row by 32-bit
// memory and allocate scans it one row per cycle, over at most a full
// 1024-entry range; on an empty range it gives its result without a scan.
// Release reads the row, then writes it back; clear and unused codes go
// straight to the result.
// The next item is accepted in the cycle after the result is loaded into the
// output register, even while that result is still held.
// Reset frees every identifier at once through per-row valid bits (no
// clearing pass), loads lowest_id 100 and id_span 901, and starts the first
// search at the bottom of the range.
// While out_stall is high the result holds in the output register and the
// block finishes at most one more item before it stalls its input.
`default_nettype none

module next_fit_id_allocator_core import nfa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [ACT_W-1:0] action,
	input  wire logic [ID_W-1:0]  requested_id,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [ID_W-1:0]       issued_id,
	output logic [ST_W-1:0]       status,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic             cfg_index,
	input  wire logic [ID_W-1:0]  cfg_data
);

	logic [ID_W-1:0]   lowest_id_q;
	logic [SPAN_W-1:0] id_span_q;
	logic [SPAN_W-1:0] span_eff;
	logic              out_valid_q;
	logic [ID_W-1:0]   issued_id_q;
	logic [ST_W-1:0]   status_q;
	logic              out_free;
	cfg_t              cfg;
	ctrl_cmd_t         cmd;
	dp_status_t        dp_status;
	logic [ID_W-1:0]   res_id;
	logic [ST_W-1:0]   res_status;

	assign cfg_ready  = 1'b1;
	assign span_eff   = (id_span_q > SPAN_W'(CAPACITY)) ? SPAN_W'(CAPACITY) : id_span_q;
	assign cfg.lowest = lowest_id_q;
	assign cfg.span   = span_eff;
	assign out_free   = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lowest_id_q <= ID_W'(RESET_LOWEST);
			id_span_q   <= SPAN_W'(RESET_SPAN);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LOWEST_ID: lowest_id_q <= cfg_data;
				CFG_ID_SPAN:   id_span_q   <= cfg_data[SPAN_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			issued_id_q <= res_id;
			status_q    <= res_status;
		end
	end

	assign out_valid = out_valid_q;
	assign issued_id = issued_id_q;
	assign status    = status_q;

	nfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.dp_status (dp_status),
		.out_free  (out_free),
		.cmd       (cmd),
		.in_stall  (in_stall)
	);

	nfa_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.action       (action),
		.requested_id (requested_id),
		.dp_status    (dp_status),
		.res_id       (res_id),
		.res_status   (res_status)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input accepted while a transaction was in flight");

	a_failed_id_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_DONE |-> issued_id == '0)
		else $error("nonzero identifier on a failed transaction");

	a_issue_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DONE && issued_id != '0
		|-> ID_W'(issued_id - lowest_id_q) < ID_W'(span_eff))
		else $error("issued identifier outside the configured range");

endmodule

`default_nettype wire

FILE: hw/rtl/nfa_datapath.sv
// Datapath of the allocator: bitmap memory with row valid bits, word scan and
// release read-modify-write. Depends on nfa_pkg; driven by nfa_ctrl commands.
`default_nettype none

module nfa_datapath import nfa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cfg_t             cfg,
	input  wire ctrl_cmd_t        cmd,
	input  wire logic [ACT_W-1:0] action,
	input  wire logic [ID_W-1:0]  requested_id,
	output dp_status_t            dp_status,
	output logic [ID_W-1:0]       res_id,
	output logic [ST_W-1:0]       res_status
);

	logic [WORD_W-1:0] mem_q [ROWS];
	logic [ROWS-1:0]   row_valid_q;
	logic [IDX_W-1:0]  last_q;
	logic [IDX_W-1:0]  start_q;
	logic [ROW_W-1:0]  rd_word_q;
	logic              rd_pass_q;
	logic [ROW_W-1:0]  word_s1;
	logic              pass_s1;
	logic              v_s1;
	logic [WORD_W-1:0] rdata_s1;
	logic              rvalid_s1;
	logic [BIT_W-1:0]  rel_bit_q;
	logic              rel_ok_q;
	logic [ID_W-1:0]   res_id_q;
	logic [ST_W-1:0]   res_status_q;

	logic              span_zero;
	logic [SPAN_W-1:0] span_m1;
	logic [ROW_W-1:0]  last_row;
	logic [SPAN_W-1:0] next_pos;
	logic [IDX_W-1:0]  start_pos;
	logic [IDX_W-1:0]  restart_last;
	logic [ID_W-1:0]   rel_off;
	logic              rel_in;
	logic [WORD_W-1:0] eff_word;
	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] free_vec;
	logic [BIT_W-1:0]  hit_bit;
	logic [IDX_W-1:0]  hit_idx;
	logic              any_free;

	function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] r;
		r = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (v[j]) begin
				r = BIT_W'(j);
			end
		end
		return r;
	endfunction

	assign span_zero    = (cfg.span == '0);
	assign span_m1      = cfg.span - SPAN_W'(1);
	assign last_row     = span_m1[IDX_W-1:BIT_W];
	assign next_pos     = SPAN_W'(last_q) + SPAN_W'(1);
	assign start_pos    = (next_pos >= cfg.span) ? '0 : next_pos[IDX_W-1:0];
	assign restart_last = span_zero ? '0 : span_m1[IDX_W-1:0];
	assign rel_off      = requested_id - cfg.lowest;
	assign rel_in       = (rel_off < ID_W'(cfg.span));
	assign eff_word     = rvalid_s1 ? rdata_s1 : '0;

	always_comb begin
		logic [IDX_W-1:0] idx;
		for (int j = 0; j < WORD_W; j++) begin
			idx = {word_s1, BIT_W'(j)};
			if (pass_s1) begin
				mask[j] = (idx < start_q);
			end else begin
				mask[j] = (idx >= start_q) && (SPAN_W'(idx) < cfg.span);
			end
		end
	end

	assign free_vec = ~eff_word & mask;
	assign any_free = |free_vec;
	assign hit_bit  = first_set(free_vec);
	assign hit_idx  = {word_s1, hit_bit};

	assign dp_status.span_zero = span_zero;
	assign dp_status.found     = v_s1 && any_free;
	assign dp_status.exhausted = v_s1 && pass_s1 && !any_free
		&& (word_s1 == start_q[IDX_W-1:BIT_W]);

	assign res_id     = res_id_q;
	assign res_status = res_status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			last_q      <= IDX_W'(RESET_LAST);
			v_s1        <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_step;
			if (cmd.load && action == ACT_CLEAR) begin
				row_valid_q <= '0;
				last_q      <= restart_last;
			end
			if (cmd.commit) begin
				row_valid_q[word_s1] <= 1'b1;
				last_q               <= hit_idx;
			end
			if (cmd.rel_write && rel_ok_q) begin
				row_valid_q[word_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rdata_s1  <= mem_q[rd_word_q];
		rvalid_s1 <= row_valid_q[rd_word_q];
		word_s1   <= rd_word_q;
		pass_s1   <= rd_pass_q;
		if (cmd.load) begin
			rd_word_q <= rel_off[IDX_W-1:BIT_W];
			rel_bit_q <= rel_off[BIT_W-1:0];
			rel_ok_q  <= rel_in;
			res_id_q  <= '0;
			if (action == ACT_ALLOC) begin
				res_status_q <= ST_NONE_FREE;
			end else if (action == ACT_RELEASE && !rel_in) begin
				res_status_q <= ST_OUT_OF_RANGE;
			end else begin
				res_status_q <= ST_DONE;
			end
		end
		if (cmd.scan_start) begin
			rd_word_q <= start_pos[IDX_W-1:BIT_W];
			rd_pass_q <= 1'b0;
			start_q   <= start_pos;
		end else if (cmd.scan_step) begin
			if (!rd_pass_q && rd_word_q == last_row) begin
				rd_word_q <= '0;
				rd_pass_q <= 1'b1;
			end else begin
				rd_word_q <= rd_word_q + ROW_W'(1);
			end
		end
		if (cmd.commit) begin
			mem_q[word_s1] <= eff_word | (WORD_W'(1) << hit_bit);
			res_id_q       <= cfg.lowest + ID_W'(hit_idx);
			res_status_q   <= ST_DONE;
		end
		if (cmd.rel_write && rel_ok_q) begin
			mem_q[word_s1] <= eff_word & ~(WORD_W'(1) << rel_bit_q);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/nfa_ctrl.sv
// Controller state machine of the allocator: sequences scan, release and result.
// Depends on nfa_pkg; drives nfa_datapath through ctrl_cmd_t.
`default_nettype none

module nfa_ctrl import nfa_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic [ACT_W-1:0] action,
	input  wire dp_status_t       dp_status,
	input  wire logic             out_free,
	output ctrl_cmd_t             cmd,
	output logic                  in_stall
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_ASTART,
		S_SCAN,
		S_RREAD,
		S_RWRITE,
		S_RESP
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   stall_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && !stall_q) begin
					cmd.load = 1'b1;
					if (action == ACT_ALLOC) begin
						state_d = S_ASTART;
					end else if (action == ACT_RELEASE) begin
						state_d = S_RREAD;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_ASTART: begin
				if (dp_status.span_zero) begin
					state_d = S_RESP;
				end else begin
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (dp_status.found) begin
					cmd.commit = 1'b1;
					state_d    = S_RESP;
				end else if (dp_status.exhausted) begin
					state_d = S_RESP;
				end
			end
			S_RREAD: begin
				state_d = S_RWRITE;
			end
			S_RWRITE: begin
				cmd.rel_write = 1'b1;
				state_d       = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_d;
			stall_q <= (state_d != S_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule

`default_nettype wire
